// ----- design/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants for the sorted insertion table
// Word field widths, operation and status codes, and the control/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

  localparam int OP_W      = 2;
  localparam int VAL_W     = 16;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_DEDUP  = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // which logical slot the memory read port looks at
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,  // slot 0
    RD_TAIL = 2'd1,  // slot count-1
    RD_SCAN = 2'd2,  // slot wr_ptr-2 (insert scan, one ahead)
    RD_DD   = 2'd3   // slot rd_ptr+1 (dedup scan, one ahead)
  } rd_sel_t;

  typedef struct packed {
    logic             take_item;
    rd_sel_t          rd_sel;
    logic             ins_step;
    logic             pop_take;
    logic             dd_first;
    logic             dd_step;
    logic             set_code;
    logic [ST_W-1:0]  code;
    logic             load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ins_done;
    logic dd_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/sit_if.sv -----
// ----------------------------------------------------------------------------
// sit_if: request and response channels of the sorted insertion table
// Valid/ready channels; a word moves on an edge where valid and ready are high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sit_req_if;
  import sit_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sit_rsp_if;
  import sit_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic [ST_W-1:0]         status;
  logic [CNT_OUT_W-1:0]    entry_count;

  modport source (output valid, output out_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input out_value, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ----- design/sit_ctrl.sv -----
// ----------------------------------------------------------------------------
// sit_ctrl: operation sequencer
// One-hot state machine that decodes a request word and steps the datapath
// through insert, pop and dedup scans, then hands the result to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sit_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  input  wire logic [sit_pkg::OP_W-1:0] req_op,
  output logic                          req_ready,
  input  wire sit_pkg::dp_stat_t        stat,
  output sit_pkg::dp_cmd_t              cmd
);
  import sit_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_POP  = 6'b000100,
    S_DDF  = 6'b001000,
    S_DDS  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_op == OP_INSERT) begin
          cmd.rd_sel = RD_TAIL;
        end
        if (req_valid) begin
          cmd.take_item = 1'b1;
          case (req_op)
            OP_INSERT: begin
              if (stat.full) begin
                cmd.set_code = 1'b1;
                cmd.code     = ST_FULL;
                state_next   = S_RESP;
              end else begin
                state_next = S_INS;
              end
            end
            OP_POP: begin
              if (stat.empty) begin
                cmd.set_code = 1'b1;
                cmd.code     = ST_EMPTY;
                state_next   = S_RESP;
              end else begin
                state_next = S_POP;
              end
            end
            OP_DEDUP: begin
              state_next = stat.empty ? S_RESP : S_DDF;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_INS: begin
        cmd.rd_sel   = RD_SCAN;
        cmd.ins_step = 1'b1;
        if (stat.ins_done) begin
          state_next = S_RESP;
        end
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        state_next   = S_RESP;
      end
      S_DDF: begin
        cmd.rd_sel   = RD_DD;
        cmd.dd_first = 1'b1;
        state_next   = S_DDS;
      end
      S_DDS: begin
        cmd.rd_sel  = RD_DD;
        cmd.dd_step = 1'b1;
        if (stat.dd_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/sit_dp.sv -----
// ----------------------------------------------------------------------------
// sit_dp: table storage and scan datapath
// Ring-addressed entry memory with head and count, insert/dedup scan
// pointers, a pending result and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sit_dp #(
  parameter int CAPACITY = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sit_pkg::dp_cmd_t                  cmd,
  output sit_pkg::dp_stat_t                      stat,
  input  wire logic signed [sit_pkg::VAL_W-1:0]  in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [sit_pkg::VAL_W-1:0]       out_value,
  output logic [sit_pkg::ST_W-1:0]               out_status,
  output logic [sit_pkg::CNT_OUT_W-1:0]          out_count
);
  import sit_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  // logical slot -> physical address, relative to the ring head
  function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] lidx);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(lidx);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    if (s >= SUM_W'(CAPACITY)) begin
      s = '0;  // only for throwaway look-ahead reads
    end
    return IDX_W'(s);
  endfunction

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata;

  logic [IDX_W-1:0]        head;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        wr_ptr;
  logic [CNT_W-1:0]        rd_ptr;
  logic signed [VAL_W-1:0] vreg;
  logic signed [VAL_W-1:0] last;
  logic signed [VAL_W-1:0] res_value;
  logic [ST_W-1:0]         res_status;

  logic [CNT_W-1:0]        rd_log;
  logic [IDX_W-1:0]        rd_idx;
  logic [IDX_W-1:0]        wr_idx;
  logic                    wr_en;
  logic signed [VAL_W-1:0] wr_data;
  logic [IDX_W-1:0]        head_inc;
  logic                    ins_done;
  logic                    dd_done;
  logic                    dd_keep;

  assign ins_done = (wr_ptr == '0) || (rdata <= vreg);
  assign dd_done  = (rd_ptr == count);
  assign dd_keep  = (rdata != last);
  assign head_inc = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + IDX_W'(1);

  always_comb begin
    stat.full     = (count == CNT_W'(CAPACITY));
    stat.empty    = (count == '0);
    stat.ins_done = ins_done;
    stat.dd_done  = dd_done;
    stat.out_free = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_log = '0;
      RD_TAIL: rd_log = count - CNT_W'(1);
      RD_SCAN: rd_log = wr_ptr - CNT_W'(2);
      RD_DD:   rd_log = rd_ptr + CNT_W'(1);
      default: rd_log = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = rdata;
    if (cmd.ins_step) begin
      wr_en   = 1'b1;
      wr_data = ins_done ? vreg : rdata;
    end
    if (cmd.dd_step && !dd_done && dd_keep) begin
      wr_en = 1'b1;
    end
  end

  assign rd_idx = to_phys(head, rd_log);
  assign wr_idx = to_phys(head, wr_ptr);

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rdata <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.pop_take) begin
        head  <= head_inc;
        count <= count - CNT_W'(1);
      end
      if (cmd.ins_step && ins_done) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.dd_step && dd_done) begin
        count <= wr_ptr;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      vreg       <= in_value;
      wr_ptr     <= count;
      rd_ptr     <= '0;
      res_value  <= '0;
      res_status <= cmd.set_code ? cmd.code : ST_OK;
    end
    if (cmd.ins_step && !ins_done) begin
      wr_ptr <= wr_ptr - CNT_W'(1);
    end
    if (cmd.pop_take) begin
      res_value <= rdata;
    end
    if (cmd.dd_first) begin
      last   <= rdata;
      wr_ptr <= CNT_W'(1);
      rd_ptr <= CNT_W'(1);
    end
    if (cmd.dd_step && !dd_done) begin
      rd_ptr <= rd_ptr + CNT_W'(1);
      if (dd_keep) begin
        last   <= rdata;
        wr_ptr <= wr_ptr + CNT_W'(1);
      end
    end
    if (cmd.load_out) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_count  <= CNT_OUT_W'(count);
    end
  end

endmodule

`default_nettype wire

// ----- design/sorted_insertion_table.sv -----
// ----------------------------------------------------------------------------
// sorted_insertion_table: bounded ascending table of signed 16-bit values
// Insert, pop-smallest and adjacent-duplicate removal, one response word per
// request word, built as a sequencer plus a memory-based datapath.
// ----------------------------------------------------------------------------
// Scans: insert shifts up each stored entry greater than the value; dedup
//   steps through the stored entries; full insert, empty pop/dedup and code 3
//   skip the scan and go straight to the response.
// Throughput: one word in flight; the next request is taken once the result
//   sits in the output register, so a stalled response overlaps one request.
// Reset (rst, synchronous): clears count, ring head and output valid; the
//   entry memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insertion_table #(
  parameter int CAPACITY = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sit_req_if.sink    req,
  sit_rsp_if.source  rsp
);
  import sit_pkg::*;

  // Storage is a ring: pop just advances the head, so only insert and
  // dedup need to walk entries. Insert scans from the tail toward the head,
  // shifting each larger entry up one slot until it finds the gap; the
  // memory read for the next slot is issued ahead of the write so the scan
  // moves one entry per clock. Dedup walks forward with a read pointer and
  // a compacting write pointer, keeping the last kept value in a register.

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sit_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (req.value),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_value  (rsp.out_value),
    .out_status (rsp.status),
    .out_count  (rsp.entry_count)
  );

endmodule

`default_nettype wire

// ----- design/sit_checker.sv -----
// ----------------------------------------------------------------------------
// sit_checker: port-level checks for the sorted insertion table
// Watches request and response words over time and flags inconsistencies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sit_checker #(
  parameter int CAPACITY = 32
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              req_valid,
  input wire logic                              req_ready,
  input wire logic                              rsp_valid,
  input wire logic                              rsp_ready,
  input wire logic signed [sit_pkg::VAL_W-1:0]  rsp_value,
  input wire logic [sit_pkg::ST_W-1:0]          rsp_status,
  input wire logic [sit_pkg::CNT_OUT_W-1:0]     rsp_count
);
  import sit_pkg::*;

  // one request at a time: ready drops right after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // a dropped insert leaves the table at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |->
      rsp_count == CNT_OUT_W'(CAPACITY) && rsp_value == '0)
    else $error("full status with wrong count or value");

  // an empty pop reports an empty table and a zero value
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0 && rsp_value == '0)
    else $error("empty status with nonzero count or value");

  // stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_value) && $stable(rsp_status) && $stable(rsp_count))
    else $error("response changed while stalled");

endmodule

bind sorted_insertion_table sit_checker #(
  .CAPACITY (CAPACITY)
) u_sit_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.out_value),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.entry_count)
);

`default_nettype wire

// ----- bench/sit_table_checker.sv -----
// ----------------------------------------------------------------------------
// sit_table_checker: response checker for the sorted insertion table
// Watches both channels, keeps a shadow copy of the ordered table, predicts
// one response word per request word and compares responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sit_table_checker #(
  parameter int CAPACITY = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  sit_req_if        req,
  sit_rsp_if        rsp,
  output int        fails,
  output int        pending
);
  import sit_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic [ST_W-1:0]         status;
    logic [CNT_OUT_W-1:0]    entry_count;
  } rsp_word_t;

  logic signed [VAL_W-1:0] shadow [CAPACITY];
  int                      shadow_fill;
  rsp_word_t               due_words[$];

  // applies one request to the shadow table, returns the response it owes
  function automatic rsp_word_t apply_request(input logic [OP_W-1:0] op,
                                              input logic signed [VAL_W-1:0] v);
    rsp_word_t r;
    int        pos;
    int        k;
    int        wr;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // new value lands after any equal entries
          pos = 0;
          while (pos < shadow_fill && shadow[pos] <= v) pos++;
          for (k = shadow_fill; k > pos; k--) shadow[k] = shadow[k-1];
          shadow[pos] = v;
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = shadow[0];
          for (k = 1; k < shadow_fill; k++) shadow[k-1] = shadow[k];
          shadow_fill--;
        end
      end
      OP_DEDUP: begin
        if (shadow_fill > 0) begin
          wr = 1;
          for (k = 1; k < shadow_fill; k++) begin
            if (shadow[k] != shadow[wr-1]) begin
              shadow[wr] = shadow[k];
              wr++;
            end
          end
          shadow_fill = wr;
        end
      end
      default: ;  // spare code: no change
    endcase
    r.entry_count = CNT_OUT_W'(shadow_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t got;
    int        delta;
    if (rst) begin
      shadow_fill = 0;
      due_words.delete();
      fails   <= 0;
      pending <= 0;
    end else begin
      delta = 0;
      // response first: a word taken on this edge belongs to an older request
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.out_value, rsp.status, rsp.entry_count};
        delta--;
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word: value %0d status %0d count %0d",
                   $time, got.out_value, got.status, got.entry_count);
          fails <= fails + 1;
        end else begin
          want = due_words.pop_front();
          if (got != want) begin
            $display("%0t: mismatch: expected value %0d status %0d count %0d, got value %0d status %0d count %0d",
                     $time, want.out_value, want.status, want.entry_count,
                     got.out_value, got.status, got.entry_count);
            fails <= fails + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        due_words.push_back(apply_request(req.operation, req.value));
        delta++;
      end
      pending <= pending + delta;
    end
  end

endmodule

// ----- bench/tb_sorted_insertion_table.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_insertion_table: testbench top for the sorted insertion table
// Drives request words (directed corner cases, then random fill, drain,
// mixed and duplicate-heavy runs), throttles the response side, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_insertion_table;
  import sit_pkg::*;

  localparam int              DEPTH       = 32;
  localparam logic [OP_W-1:0] OP_SPARE    = 2'd3;   // unused code, acts as no-op
  localparam int              ITEM_GOAL   = 1400;
  localparam int              CALM_FROM   = 1250;   // no idling past this word count
  localparam int              LONG_HOLD   = 400;    // one long response back-pressure
  localparam int              SETTLE      = 60;     // > worst latency (dedup of a full table)
  localparam int              STALL_LIMIT = 4000;   // cycles without any handshake

  logic clk;
  logic rst = 1'b1;

  sit_req_if req ();
  sit_rsp_if rsp ();

  int fails;
  int pending;

  // stimulus <-> response-side coordination
  bit calm;          // set near the end: both sides stop idling
  bit hold_ask;      // stimulus asks for the long hold
  bit hold_taken;    // response side has started it
  int gap_pct = 20;  // chance per word of a sender idle burst
  int sent;          // request words accepted so far
  int quiet_cycles;

  sorted_insertion_table #(.CAPACITY(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  sit_table_checker #(.CAPACITY(DEPTH)) table_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Value mix: full-range random covers every bit; small ranges make
  // duplicates for the insert-after-equal and dedup paths; extremes hit the
  // signed compare at both ends.
  // --------------------------------------------------------------------------
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = VAL_W'($urandom);
      2:    v = VAL_W'(int'($urandom_range(0, 8)) - 4);
      3: begin
        case ($urandom_range(0, 3))
          0:       v = 16'sh8000;
          1:       v = 16'sh7fff;
          2:       v = 16'sh8001;
          default: v = 16'sh7ffe;
        endcase
      end
      default: v = VAL_W'(int'($urandom_range(0, 600)) - 300);
    endcase
    return v;
  endfunction

  // One request word. Optional idle burst first, then hold valid until taken.
  // Called right at a clock edge; valid gets one assignment per edge.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.value     <= v;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  // Sender pauses until every owed response has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side: random ready bursts, one long hold on request, and ready
  // held high once the run goes calm.
  // --------------------------------------------------------------------------
  initial begin
    rsp.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_ask && !hold_taken) begin
        hold_taken = 1'b1;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Watchdog: any stretch without a handshake on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int  phase;
    int  n;
    int  r;
    bit  mid_drain_done;
    req.valid     = 1'b0;
    req.operation = OP_INSERT;
    req.value     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: empty table first
    send_word(OP_POP, pick_value());    // pop of empty table
    send_word(OP_DEDUP, pick_value());  // dedup of empty table
    send_word(OP_SPARE, pick_value());  // spare code on empty table
    // extremes and equal values (new one goes after the equal ones)
    send_word(OP_INSERT, 16'sh0000);
    send_word(OP_INSERT, 16'sh7fff);
    send_word(OP_INSERT, 16'sh8000);
    send_word(OP_INSERT, 16'shffff);
    send_word(OP_INSERT, 16'sh0000);
    send_word(OP_INSERT, 16'sh7fff);
    send_word(OP_INSERT, 16'sh8000);
    send_word(OP_SPARE, 16'sh5a5a);
    send_word(OP_DEDUP, 16'sha5a5);
    send_word(OP_POP, 16'sh0000);
    send_word(OP_INSERT, 16'sh0001);
    send_word(OP_INSERT, 16'sh0001);
    send_word(OP_INSERT, 16'shfffe);
    send_word(OP_DEDUP, 16'shffff);
    repeat (7) send_word(OP_POP, pick_value());  // drains past empty

    // random part in phases of differing shape
    while (sent < ITEM_GOAL) begin
      if (sent >= CALM_FROM) calm = 1'b1;
      gap_pct = calm ? 0 : ($urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 15 : 45));
      phase = $urandom_range(0, 3);

      // long response hold while the sender keeps offering inserts
      if (!hold_ask && sent >= 300) begin
        hold_ask = 1'b1;
        phase = 0;
      end
      // sender pause until everything is back: once for sure, sometimes more
      if ((!mid_drain_done && sent >= 700) || $urandom_range(0, 9) == 0) begin
        mid_drain_done = 1'b1;
        wait_drained();
      end

      case (phase)
        0: begin
          // fill: enough inserts to reach full and see drops
          n = $urandom_range(34, 40);
          repeat (n) send_word(OP_INSERT, pick_value());
        end
        1: begin
          // drain, often past empty
          n = $urandom_range(10, 40);
          repeat (n) send_word(OP_POP, pick_value());
        end
        2: begin
          repeat (40) begin
            r = $urandom_range(0, 99);
            if (r < 45)      send_word(OP_INSERT, pick_value());
            else if (r < 80) send_word(OP_POP, pick_value());
            else if (r < 95) send_word(OP_DEDUP, pick_value());
            else             send_word(OP_SPARE, pick_value());
          end
        end
        default: begin
          // duplicate-heavy run, then dedup and a few pops
          n = $urandom_range(12, 30);
          repeat (n) send_word(OP_INSERT, VAL_W'(int'($urandom_range(0, 3)) - 1));
          send_word(OP_DEDUP, pick_value());
          n = $urandom_range(0, 8);
          repeat (n) send_word(OP_POP, pick_value());
        end
      endcase
    end

    calm = 1'b1;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
